// ----- rtl/core/b64d_pkg.sv -----
package b64d_pkg;

  localparam int CHAR_W      = 8;
  localparam int OUT_CNT_W   = 24;
  localparam int ERR_W       = 2;
  localparam int SEXTET_W    = 6;
  localparam int COUNT_BITS  = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CHAR_W-1:0]    CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0]    CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0]    CHAR_PAD   = 8'h3D;
  localparam logic [CHAR_W-1:0]    CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0]    CHAR_NUL   = 8'h00;
  localparam logic [SEXTET_W-1:0]  SYM_PLUS   = 6'd62;
  localparam logic [SEXTET_W-1:0]  SYM_SLASH  = 6'd63;
  localparam logic [OUT_CNT_W-1:0] CNT_FIELD_MAX = 24'hFFFFFF;

  // Register word index on the configuration port.
  localparam logic REG_COUNT_ONLY = 1'b0;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_GROUP = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY     = 2'd2;

  typedef enum logic [1:0] {
    PH_START     = 2'd0,
    PH_PLUS_HELD = 2'd1,
    PH_EMPTY     = 2'd2,
    PH_BODY      = 2'd3
  } phase_t;

  // Everything one input character produces: up to three bytes and a status.
  typedef struct packed {
    logic [2:0][CHAR_W-1:0] bytes;
    logic [1:0]             nbytes;
    logic                   has_status;
    logic [ERR_W-1:0]       err;
    logic [OUT_CNT_W-1:0]   cnt;
  } bundle_t;

  // Returns {valid, value} for one Base64 alphabet character.
  function automatic logic [SEXTET_W:0] sym_value(input logic [CHAR_W-1:0] c);
    logic [SEXTET_W:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, SEXTET_W'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, SEXTET_W'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, SEXTET_W'(c - 8'h30 + 8'd52)};
    end else if (c == CHAR_PLUS) begin
      r = {1'b1, SYM_PLUS};
    end else if (c == CHAR_SLASH) begin
      r = {1'b1, SYM_SLASH};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/b64d_decode.sv -----
module b64d_decode #(
  parameter int COUNT_BITS = b64d_pkg::COUNT_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        count_only,
  input  logic                        item_take,
  input  logic [b64d_pkg::CHAR_W-1:0] char_code,
  input  logic                        end_of_text,
  output logic                        push,
  output b64d_pkg::bundle_t           bundle
);

  localparam int CW = (COUNT_BITS > b64d_pkg::OUT_CNT_W) ? COUNT_BITS : b64d_pkg::OUT_CNT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [2:0][b64d_pkg::SEXTET_W-1:0] sext_r, sext_nxt;
  logic                               tpad_r, tpad_nxt;
  logic                               bad_r, bad_nxt;
  logic [1:0]                         gpos_r, gpos_nxt;
  b64d_pkg::phase_t                   phase_r, phase_nxt;
  logic                               fault_r, fault_nxt;
  logic [b64d_pkg::ERR_W-1:0]         kind_r, kind_nxt;
  logic [COUNT_BITS-1:0]              total_r, total_nxt;

  logic                               held_feed;
  logic                               feed_active;
  logic [b64d_pkg::SEXTET_W:0]        sym;
  logic                               is_pad;
  logic [2:0][b64d_pkg::SEXTET_W-1:0] b_sext;
  logic                               b_tpad;
  logic                               b_bad;
  logic [1:0]                         b_gpos;
  logic                               b_in_body;
  logic                               f_fault;
  logic [b64d_pkg::ERR_W-1:0]         f_kind;
  logic                               bad_all;
  logic [1:0]                         nbytes;
  logic [COUNT_BITS:0]                sum;
  logic [CW-1:0]                      total_ext;

  // A held leading plus that is not followed by a space becomes body character one.
  assign held_feed = (phase_r == b64d_pkg::PH_PLUS_HELD) && (char_code != b64d_pkg::CHAR_SPACE);
  assign feed_active = held_feed || (phase_r == b64d_pkg::PH_EMPTY) ||
                       (phase_r == b64d_pkg::PH_BODY) ||
                       ((phase_r == b64d_pkg::PH_START) && (char_code != b64d_pkg::CHAR_PLUS));
  assign sym    = b64d_pkg::sym_value(char_code);
  assign is_pad = (char_code == b64d_pkg::CHAR_PAD);

  always_comb begin
    phase_nxt = phase_r;
    if (feed_active) begin
      phase_nxt = b64d_pkg::PH_BODY;
    end else if (phase_r == b64d_pkg::PH_START) begin
      phase_nxt = b64d_pkg::PH_PLUS_HELD;
    end else if (phase_r == b64d_pkg::PH_PLUS_HELD) begin
      phase_nxt = b64d_pkg::PH_EMPTY;
    end
    if (end_of_text) begin
      phase_nxt = b64d_pkg::PH_START;
    end
  end

  always_comb begin
    b_sext    = sext_r;
    b_tpad    = tpad_r;
    b_bad     = bad_r;
    b_gpos    = gpos_r;
    b_in_body = (phase_r == b64d_pkg::PH_BODY);
    if (held_feed) begin
      b_sext[0] = b64d_pkg::SYM_PLUS;
      b_tpad    = 1'b0;
      b_bad     = 1'b0;
      b_gpos    = 2'd1;
      b_in_body = 1'b1;
    end

    f_fault = fault_r;
    f_kind  = kind_r;
    if (feed_active && !b_in_body && (char_code == b64d_pkg::CHAR_NUL) && !fault_r) begin
      f_fault = 1'b1;
      f_kind  = b64d_pkg::ERR_EMPTY;
    end

    sext_nxt = b_sext;
    tpad_nxt = b_tpad;
    bad_nxt  = b_bad;
    gpos_nxt = b_gpos;
    bad_all  = b_bad || (!sym[b64d_pkg::SEXTET_W] && !is_pad);
    nbytes   = 2'd0;
    if (feed_active) begin
      case (b_gpos)
        2'd0, 2'd1: begin
          bad_nxt           = b_bad || !sym[b64d_pkg::SEXTET_W];
          sext_nxt[b_gpos]  = sym[b64d_pkg::SEXTET_W-1:0];
          gpos_nxt          = b_gpos + 2'd1;
        end
        2'd2: begin
          bad_nxt     = bad_all;
          sext_nxt[2] = sym[b64d_pkg::SEXTET_W-1:0];
          tpad_nxt    = is_pad;
          gpos_nxt    = 2'd3;
        end
        default: begin
          if (!f_fault) begin
            if (bad_all) begin
              f_fault = 1'b1;
              f_kind  = b64d_pkg::ERR_BAD_GROUP;
            end else if (b_tpad) begin
              nbytes = 2'd1;
            end else if (is_pad) begin
              nbytes = 2'd2;
            end else begin
              nbytes = 2'd3;
            end
          end
          gpos_nxt = 2'd0;
          bad_nxt  = 1'b0;
          tpad_nxt = 1'b0;
        end
      endcase
    end

    sum       = {1'b0, total_r} + (COUNT_BITS + 1)'(nbytes);
    total_nxt = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
    fault_nxt = f_fault;
    kind_nxt  = f_kind;
    total_ext = CW'(total_nxt);

    bundle.bytes[0]   = {b_sext[0], b_sext[1][5:4]};
    bundle.bytes[1]   = {b_sext[1][3:0], b_sext[2][5:2]};
    bundle.bytes[2]   = {b_sext[2][1:0], sym[b64d_pkg::SEXTET_W-1:0]};
    bundle.nbytes     = count_only ? 2'd0 : nbytes;
    bundle.has_status = end_of_text;
    if (f_fault) begin
      bundle.err = f_kind;
    end else if (phase_nxt == b64d_pkg::PH_EMPTY ||
                 (end_of_text && !feed_active && phase_r == b64d_pkg::PH_PLUS_HELD)) begin
      bundle.err = b64d_pkg::ERR_EMPTY;
    end else begin
      bundle.err = b64d_pkg::ERR_OK;
    end
    if (bundle.err != b64d_pkg::ERR_OK) begin
      bundle.cnt = '0;
    end else if (total_ext > CW'(b64d_pkg::CNT_FIELD_MAX)) begin
      bundle.cnt = b64d_pkg::CNT_FIELD_MAX;
    end else begin
      bundle.cnt = total_ext[b64d_pkg::OUT_CNT_W-1:0];
    end
  end

  assign push = item_take && (end_of_text || (bundle.nbytes != 2'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sext_r  <= '0;
      tpad_r  <= 1'b0;
      bad_r   <= 1'b0;
      gpos_r  <= 2'd0;
      phase_r <= b64d_pkg::PH_START;
      fault_r <= 1'b0;
      kind_r  <= b64d_pkg::ERR_OK;
      total_r <= '0;
    end else if (item_take) begin
      if (end_of_text) begin
        sext_r  <= '0;
        tpad_r  <= 1'b0;
        bad_r   <= 1'b0;
        gpos_r  <= 2'd0;
        phase_r <= b64d_pkg::PH_START;
        fault_r <= 1'b0;
        kind_r  <= b64d_pkg::ERR_OK;
        total_r <= '0;
      end else begin
        sext_r  <= sext_nxt;
        tpad_r  <= tpad_nxt;
        bad_r   <= bad_nxt;
        gpos_r  <= gpos_nxt;
        phase_r <= phase_nxt;
        fault_r <= fault_nxt;
        kind_r  <= kind_nxt;
        total_r <= total_nxt;
      end
    end
  end

endmodule

// ----- rtl/core/b64d_outq.sv -----
module b64d_outq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  b64d_pkg::bundle_t              bundle,
  output logic                           full,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [b64d_pkg::CHAR_W-1:0]    data_byte,
  output logic                           byte_valid,
  output logic                           status_valid,
  output logic [b64d_pkg::ERR_W-1:0]     error_code,
  output logic [b64d_pkg::OUT_CNT_W-1:0] byte_count,
  output logic                           last_of_run
);

  b64d_pkg::bundle_t slot_r [2];
  logic              wptr_r;
  logic              rptr_r;
  logic [1:0]        fill_r;
  logic [1:0]        idx_r;
  b64d_pkg::bundle_t head;
  logic              is_byte;
  logic              pop;

  assign head      = slot_r[rptr_r];
  assign full      = (fill_r == 2'd2);
  assign out_valid = (fill_r != 2'd0);
  assign is_byte   = (idx_r < head.nbytes);

  always_comb begin
    data_byte    = '0;
    byte_valid   = 1'b0;
    status_valid = 1'b0;
    error_code   = b64d_pkg::ERR_OK;
    byte_count   = '0;
    last_of_run  = 1'b1;
    if (is_byte) begin
      data_byte   = head.bytes[idx_r];
      byte_valid  = 1'b1;
      last_of_run = !head.has_status && (idx_r == head.nbytes - 2'd1);
    end else begin
      status_valid = 1'b1;
      error_code   = head.err;
      byte_count   = head.cnt;
    end
  end

  // The head bundle leaves the queue with its last result transfer.
  assign pop = out_valid && out_ready && last_of_run;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
      idx_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
        idx_r  <= 2'd0;
      end else if (out_valid && out_ready) begin
        idx_r <= idx_r + 2'd1;
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/core/base64_padded_decoder.sv -----
// Base64 decoder, one text character per input transfer.
// The input channel carries the character code in in_tdata and marks the last
// character of a string with in_tlast. A leading plus-space pair is dropped.
// Every complete group of four characters yields up to three byte results on
// the output channel; the last input of a string also yields a status result
// with the error code and the decoded byte count. out_tlast marks the final
// result caused by one input. Setting count_only suppresses byte results.
// Throughput is one character per cycle while the result queue is not full; an
// input whose results wait in the two-entry result queue does not block the
// next character. A character's results are written into the queue when it is
// taken and leave it in order, one per output transfer.
// Reset (synchronous, active low) clears the decoding state, the result queue
// and count_only. When the receiver stalls, results are held in the queue and
// in_tready drops once both queue entries are taken.
module base64_padded_decoder #(
  parameter int COUNT_BITS = b64d_pkg::COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [b64d_pkg::CHAR_W-1:0]         in_tdata,  // [7:0] char_code
  input  logic                                in_tlast,  // end_of_text
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] data_byte, [9:8] error_code, [33:10] byte_count, [39:34] zero
  output logic [b64d_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [b64d_pkg::OUT_TUSER_W-1:0]    out_tuser, // [0] byte_valid, [1] status_valid
  output logic                                out_tlast, // last_of_run
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [b64d_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [b64d_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [b64d_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  logic                                count_only_r;
  logic                                take;
  logic                                push;
  logic                                full;
  b64d_pkg::bundle_t                   bundle;
  logic [b64d_pkg::CHAR_W-1:0]         data_byte;
  logic                                byte_valid;
  logic                                status_valid;
  logic [b64d_pkg::ERR_W-1:0]          error_code;
  logic [b64d_pkg::OUT_CNT_W-1:0]      byte_count;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[b64d_pkg::CFG_ADDR_W-1] == b64d_pkg::REG_COUNT_ONLY) ?
                      {{(b64d_pkg::CFG_DATA_W-1){1'b0}}, count_only_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_only_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[b64d_pkg::CFG_ADDR_W-1] == b64d_pkg::REG_COUNT_ONLY) begin
      count_only_r <= cfg_pwdata[0];
    end
  end

  assign in_tready = rst_n && !full;
  assign take      = in_tvalid && in_tready;

  b64d_decode #(
    .COUNT_BITS(COUNT_BITS)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .count_only (count_only_r),
    .item_take  (take),
    .char_code  (in_tdata),
    .end_of_text(in_tlast),
    .push       (push),
    .bundle     (bundle)
  );

  b64d_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .bundle      (bundle),
    .full        (full),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .status_valid(status_valid),
    .error_code  (error_code),
    .byte_count  (byte_count),
    .last_of_run (out_tlast)
  );

  assign out_tdata = {6'd0, byte_count, error_code, data_byte};
  assign out_tuser = {status_valid, byte_valid};

endmodule

// ----- rtl/core/b64d_checker.sv -----
module b64d_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [b64d_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [b64d_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                             out_tlast
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result channel valid right after reset");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] ^ out_tuser[1]))
    else $error("result is not exactly one of byte or status");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tlast)
    else $error("status result is not the last of its run");

  a_err_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1] && out_tdata[9:8] != b64d_pkg::ERR_OK) |->
    (out_tdata[33:10] == '0))
    else $error("failed status carries a byte count");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind base64_padded_decoder b64d_checker u_b64d_checker (.*);

// ----- tb/b64_decode_checker.sv -----
module b64_decode_checker
  import b64d_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [CHAR_W-1:0]      in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   out_tlast,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  input  logic                   cfg_pready,
  output int                     failures,
  output int                     results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]           data_byte;
    logic                 byte_valid;
    logic                 status_valid;
    logic [ERR_W-1:0]     error_code;
    logic [OUT_CNT_W-1:0] byte_count;
    logic                 last_of_run;
  } decoded_result_t;

  localparam logic [COUNT_BITS-1:0] TOTAL_MAX = '1;

  // Decoder state as the string is parsed.
  logic [SEXTET_W-1:0]   sextets [3];
  logic                  third_pad;
  logic                  group_bad;
  logic [1:0]            group_pos;
  phase_t                phase;
  logic                  fault_seen;
  logic [ERR_W-1:0]      fault_code;
  logic [COUNT_BITS-1:0] decoded_total;
  logic                  count_only;

  decoded_result_t char_results[$];
  decoded_result_t expected_results[$];
  int              mismatch_total;

  // Returns {is_symbol, sextet} for one character.
  function automatic logic [SEXTET_W:0] sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return {1'b1, SEXTET_W'(c - 8'h41)};
    if (c >= "a" && c <= "z") return {1'b1, SEXTET_W'(c - 8'h61 + 8'd26)};
    if (c >= "0" && c <= "9") return {1'b1, SEXTET_W'(c - 8'h30 + 8'd52)};
    if (c == CHAR_PLUS) return {1'b1, SYM_PLUS};
    if (c == CHAR_SLASH) return {1'b1, SYM_SLASH};
    return '0;
  endfunction

  task automatic clear_string();
    foreach (sextets[i]) sextets[i] = '0;
    third_pad     = 1'b0;
    group_bad     = 1'b0;
    group_pos     = 2'd0;
    phase         = PH_START;
    fault_seen    = 1'b0;
    fault_code    = ERR_OK;
    decoded_total = '0;
  endtask

  task automatic raise_fault(input logic [ERR_W-1:0] code);
    if (!fault_seen) begin
      fault_seen = 1'b1;
      fault_code = code;
    end
  endtask

  task automatic emit_byte(input logic [7:0] b);
    decoded_result_t r;
    if (decoded_total != TOTAL_MAX) decoded_total++;
    if (!count_only) begin
      r = '0;
      r.data_byte  = b;
      r.byte_valid = 1'b1;
      char_results.push_back(r);
    end
  endtask

  task automatic feed_body(input logic [7:0] c);
    logic [SEXTET_W:0]   lk;
    logic                is_pad;
    logic [SEXTET_W-1:0] s;
    lk     = sextet_of(c);
    is_pad = (c == CHAR_PAD);
    s      = lk[SEXTET_W] ? lk[SEXTET_W-1:0] : '0;
    if (phase != PH_BODY && c == CHAR_NUL) raise_fault(ERR_EMPTY);
    phase = PH_BODY;
    case (group_pos)
      2'd0, 2'd1: begin
        if (!lk[SEXTET_W]) group_bad = 1'b1;
        sextets[group_pos[0]] = s;
        group_pos++;
      end
      2'd2: begin
        if (!lk[SEXTET_W] && !is_pad) group_bad = 1'b1;
        sextets[2] = s;
        third_pad  = is_pad;
        group_pos  = 2'd3;
      end
      default: begin
        if (!lk[SEXTET_W] && !is_pad) group_bad = 1'b1;
        if (!fault_seen) begin
          if (group_bad) begin
            raise_fault(ERR_BAD_GROUP);
          end else begin
            emit_byte({sextets[0], sextets[1][5:4]});
            if (!third_pad) begin
              emit_byte({sextets[1][3:0], sextets[2][5:2]});
              if (!is_pad) emit_byte({sextets[2][1:0], s});
            end
          end
        end
        group_pos = 2'd0;
        group_bad = 1'b0;
        third_pad = 1'b0;
      end
    endcase
  endtask

  task automatic predict_char(input logic [7:0] c, input logic end_of_text);
    decoded_result_t r;
    char_results.delete();
    case (phase)
      PH_START: begin
        if (c == CHAR_PLUS) phase = PH_PLUS_HELD;
        else feed_body(c);
      end
      PH_PLUS_HELD: begin
        if (c == CHAR_SPACE) begin
          phase = PH_EMPTY;
        end else begin
          // The held plus turns out to be the first body character.
          feed_body(CHAR_PLUS);
          feed_body(c);
        end
      end
      default: feed_body(c);
    endcase
    if (end_of_text) begin
      r = '0;
      r.status_valid = 1'b1;
      if (fault_seen) r.error_code = fault_code;
      else if (phase == PH_EMPTY) r.error_code = ERR_EMPTY;
      else r.error_code = ERR_OK;
      if (r.error_code == ERR_OK) begin
        r.byte_count = (decoded_total > CNT_FIELD_MAX) ? CNT_FIELD_MAX
                                                       : OUT_CNT_W'(decoded_total);
      end
      char_results.push_back(r);
      clear_string();
    end
    if (char_results.size() > 0) begin
      r = char_results.pop_back();
      r.last_of_run = 1'b1;
      char_results.push_back(r);
    end
    foreach (char_results[i]) expected_results.push_back(char_results[i]);
  endtask

  task automatic compare_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_total++;
    end
  endtask

  initial mismatch_total = 0;

  always @(posedge clk) begin
    decoded_result_t got;
    decoded_result_t want;
    if (!rst_n) begin
      clear_string();
      count_only = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {REG_COUNT_ONLY, 2'b00}) begin
        count_only = cfg_pwdata[0];
      end
      // Results are checked before this edge's input, which cannot answer yet.
      if (out_tvalid && out_tready) begin
        got.data_byte    = out_tdata[7:0];
        got.error_code   = out_tdata[9:8];
        got.byte_count   = out_tdata[33:10];
        got.byte_valid   = out_tuser[0];
        got.status_valid = out_tuser[1];
        got.last_of_run  = out_tlast;
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: tdata %h tuser %b tlast %b",
                 out_tdata, out_tuser, out_tlast);
          mismatch_total++;
        end else begin
          want = expected_results.pop_front();
          compare_field("data_byte", want.data_byte, got.data_byte);
          compare_field("byte_valid", want.byte_valid, got.byte_valid);
          compare_field("status_valid", want.status_valid, got.status_valid);
          compare_field("error_code", want.error_code, got.error_code);
          compare_field("byte_count", want.byte_count, got.byte_count);
          compare_field("last_of_run", want.last_of_run, got.last_of_run);
          compare_field("tdata_padding", '0, out_tdata[39:34]);
        end
      end
      if (in_tvalid && in_tready) predict_char(in_tdata, in_tlast);
    end
    failures        <= mismatch_total;
    results_pending <= expected_results.size();
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import b64d_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 300;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [CHAR_W-1:0]      in_tdata;     // [7:0] char_code
  logic                   in_tlast;     // end_of_text
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;    // [7:0] data_byte, [9:8] error_code, [33:10] byte_count
  logic [OUT_TUSER_W-1:0] out_tuser;    // [0] byte_valid, [1] status_valid
  logic                   out_tlast;    // last_of_run
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int   failures;
  int   results_pending;
  int   cycle_count = 0;
  int   send_burst  = 0;
  int   recv_burst  = 0;
  bit   hold_request = 1'b0;
  logic [7:0] text_q[$];

  base64_padded_decoder u_dut (.*);

  b64_decode_checker u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .failures, .results_pending
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly random gaps, with occasional stretches of back-to-back transfers.
  function automatic int draw_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) burst_left = $urandom_range(8, 30);
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [7:0] symbol_char(input int unsigned v);
    if (v < 26) return 8'h41 + 8'(v);
    if (v < 52) return 8'h61 + 8'(v - 26);
    if (v < 62) return 8'h30 + 8'(v - 52);
    if (v == 62) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  // Sends text_q as one string; in_tvalid stays high after the last transfer.
  task automatic send_text();
    int w;
    foreach (text_q[i]) begin
      w = draw_gap(send_burst);
      if (w > 0) begin
        in_tvalid <= 1'b0;
        repeat (w) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= text_q[i];
      in_tlast  <= (i == text_q.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
  endtask

  task automatic write_count_only(input logic value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_COUNT_ONLY, 2'b00};
    cfg_pwdata  <= {{(CFG_DATA_W-1){1'b0}}, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly well-formed strings with random content; the rest is noise,
  // corrupted groups and NUL-led bodies.
  task automatic run_random_phase(input int target);
    int sent;
    int kind;
    int ngroups;
    int tail;
    int body_start;
    logic [7:0] grp [4];
    sent = 0;
    while (sent < target) begin
      text_q.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 9)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          text_q.push_back(CHAR_PLUS);
          text_q.push_back(CHAR_SPACE);
        end
        body_start = text_q.size();
        ngroups = $urandom_range(0, 3);
        for (int g = 0; g < ngroups; g++) begin
          foreach (grp[k]) grp[k] = symbol_char($urandom_range(0, 63));
          if (g == ngroups - 1) begin
            case ($urandom_range(0, 3))
              1: grp[3] = CHAR_PAD;
              2: begin
                grp[2] = CHAR_PAD;
                grp[3] = CHAR_PAD;
              end
              3: grp[2] = CHAR_PAD;
              default: ;
            endcase
          end
          foreach (grp[k]) text_q.push_back(grp[k]);
        end
        tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (tail) text_q.push_back(symbol_char($urandom_range(0, 63)));
        if (text_q.size() == 0) text_q.push_back(symbol_char($urandom_range(0, 63)));
        if (kind == 1 && text_q.size() > body_start) begin
          text_q[$urandom_range(body_start, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if (kind == 2 && text_q.size() > body_start) text_q[body_start] = CHAR_NUL;
      end
      send_text();
      sent += text_q.size();
    end
  endtask

  initial begin
    int w;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        // Long hold-off so the result queue fills and the input stalls.
        hold_request = 1'b0;
        w = LONG_HOLD;
      end else begin
        w = draw_gap(recv_burst);
      end
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_count_only(1'b0);
    // A lone plus, then a prefix with nothing after it.
    text_q = '{CHAR_PLUS};
    send_text();
    text_q = '{CHAR_PLUS, CHAR_SPACE};
    send_text();
    // Held plus decoded as body, pad followed by a symbol, partial tail dropped.
    text_q = '{CHAR_PLUS, "A", CHAR_PAD, "B", CHAR_SLASH, CHAR_SLASH};
    send_text();
    text_q = '{CHAR_NUL};
    send_text();
    // Bad first group; the valid group after it must not decode.
    text_q = '{"Q", 8'hFF, CHAR_PAD, CHAR_PAD, CHAR_SLASH, CHAR_PLUS, CHAR_SLASH, "9"};
    send_text();
    text_q = '{CHAR_PLUS, CHAR_SPACE, CHAR_SLASH, CHAR_PLUS, "9", "z"};
    send_text();
    in_tvalid <= 1'b0;
    wait_drained();

    write_count_only(1'b1);
    run_random_phase(40);
    in_tvalid <= 1'b0;
    wait_drained();

    write_count_only(1'b0);
    hold_request = 1'b1;
    run_random_phase(80);
    in_tvalid <= 1'b0;
    wait_drained();

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
